### rtl/brl_pkg.sv
// ---------------------------------------------------------------------------
// brl_pkg: shared types and constants of the line rasterizer
// Field widths, frame defaults, operation codes and the structs that pass
// between the setup, stepping and pixel output stages.
// ---------------------------------------------------------------------------
package brl_pkg;

  localparam int X_W      = 10;
  localparam int Y_W      = 9;
  localparam int OFF_W    = 20;
  localparam int ERR_W    = 12;
  localparam int MAJOR_W  = 10;

  localparam int FRAME_WIDTH_DEF = 640;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } brl_op_t;

  // Line context as set up from a pair of endpoints
  typedef struct packed {
    logic                    x_is_major;
    logic                    major_step_down;
    logic                    minor_step_down;
    logic [MAJOR_W-1:0]      major_end;
    logic signed [ERR_W-1:0] error_term;
    logic signed [ERR_W-1:0] diag_inc;
    logic signed [ERR_W-1:0] straight_inc;
    logic [X_W-1:0]          x;
    logic [Y_W-1:0]          y;
  } brl_line_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           last;
  } brl_pixel_t;

  typedef struct packed {
    logic       valid;
    brl_pixel_t pix;
  } brl_emit_t;

endpackage

### rtl/brl_line_if.sv
// ---------------------------------------------------------------------------
// brl_line_if: input channel of the line rasterizer
// Carries load and step commands with the two endpoints.
// ---------------------------------------------------------------------------
interface brl_line_if;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [brl_pkg::X_W-1:0] x_start;
  logic [brl_pkg::Y_W-1:0] y_start;
  logic [brl_pkg::X_W-1:0] x_end;
  logic [brl_pkg::Y_W-1:0] y_end;

  modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

### rtl/brl_pixel_if.sv
// ---------------------------------------------------------------------------
// brl_pixel_if: output channel of the line rasterizer
// Carries one pixel: coordinates, frame buffer byte offset, last mark.
// ---------------------------------------------------------------------------
interface brl_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [brl_pkg::X_W-1:0]   pixel_x;
  logic [brl_pkg::Y_W-1:0]   pixel_y;
  logic [brl_pkg::OFF_W-1:0] pixel_offset;
  logic                      last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_offset, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_offset, last_pixel, output ready);
endinterface

### rtl/brl_setup.sv
// ---------------------------------------------------------------------------
// brl_setup: line setup from two endpoints
// Picks the major axis and forms the error term, its increments and the
// stepping directions.
// ---------------------------------------------------------------------------
module brl_setup (
  input  logic [brl_pkg::X_W-1:0] x_start,
  input  logic [brl_pkg::Y_W-1:0] y_start,
  input  logic [brl_pkg::X_W-1:0] x_end,
  input  logic [brl_pkg::Y_W-1:0] y_end,
  output brl_pkg::brl_line_t      line
);

  logic signed [brl_pkg::X_W:0]   dx;
  logic signed [brl_pkg::Y_W:0]   dy;
  logic [brl_pkg::X_W-1:0]        adx;
  logic [brl_pkg::Y_W-1:0]        ady;
  logic [brl_pkg::MAJOR_W-1:0]    major_len;
  logic [brl_pkg::MAJOR_W-1:0]    minor_len;
  logic                           x_major;

  always_comb begin
    dx  = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    dy  = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    adx = dx[brl_pkg::X_W] ? brl_pkg::X_W'(-dx) : brl_pkg::X_W'(dx);
    ady = dy[brl_pkg::Y_W] ? brl_pkg::Y_W'(-dy) : brl_pkg::Y_W'(dy);
    x_major = adx > {1'b0, ady};

    major_len = x_major ? adx : {1'b0, ady};
    minor_len = x_major ? {1'b0, ady} : adx;

    line.x_is_major      = x_major;
    line.major_end       = x_major ? x_end : {1'b0, y_end};
    // A zero delta on the major axis counts as stepping down
    line.major_step_down = x_major ? (dx[brl_pkg::X_W] || (dx == '0))
                                   : (dy[brl_pkg::Y_W] || (dy == '0));
    line.minor_step_down = x_major ? dy[brl_pkg::Y_W] : dx[brl_pkg::X_W];
    line.error_term      = $signed({1'b0, minor_len, 1'b0}) - $signed({2'b00, major_len});
    // minor never exceeds major, so this stays within -2046..0
    line.diag_inc        = $signed({1'b0, minor_len, 1'b0}) - $signed({1'b0, major_len, 1'b0});
    line.straight_inc    = $signed({1'b0, minor_len, 1'b0});
    line.x               = x_start;
    line.y               = y_start;
  end

endmodule

### rtl/brl_step.sv
// ---------------------------------------------------------------------------
// brl_step: line state and stepping
// Holds the active line, emits the current pixel on a step command and
// advances the major and minor coordinates.
// ---------------------------------------------------------------------------
module brl_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                op,
  input  brl_pkg::brl_line_t  setup,
  output brl_pkg::brl_emit_t  emit,
  output logic                line_active
);

  brl_pkg::brl_line_t           st;
  brl_pkg::brl_line_t           st_next;
  logic                         line_active_next;
  logic                         is_last;
  logic                         minor_moves;
  logic                         is_step;

  always_comb begin
    is_step     = (brl_pkg::brl_op_t'(op) == brl_pkg::OP_STEP);
    is_last     = st.x_is_major ? (st.x == st.major_end)
                                : ({1'b0, st.y} == st.major_end);
    minor_moves = st.error_term > 0;

    emit.valid    = take && is_step && line_active;
    emit.pix.x    = st.x;
    emit.pix.y    = st.y;
    emit.pix.last = is_last;

    st_next          = st;
    line_active_next = line_active;
    if (take && !is_step) begin
      st_next          = setup;
      line_active_next = 1'b1;
    end else if (emit.valid) begin
      if (is_last) begin
        line_active_next = 1'b0;
      end else begin
        st_next.error_term = st.error_term + (minor_moves ? st.diag_inc : st.straight_inc);
        if (st.x_is_major) begin
          st_next.x = st.major_step_down ? st.x - 1'b1 : st.x + 1'b1;
          if (minor_moves) begin
            st_next.y = st.minor_step_down ? st.y - 1'b1 : st.y + 1'b1;
          end
        end else begin
          st_next.y = st.major_step_down ? st.y - 1'b1 : st.y + 1'b1;
          if (minor_moves) begin
            st_next.x = st.minor_step_down ? st.x - 1'b1 : st.x + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      st          <= '0;
    end else begin
      line_active <= line_active_next;
      st          <= st_next;
    end
  end

endmodule

### rtl/brl_pixel_out.sv
// ---------------------------------------------------------------------------
// brl_pixel_out: pixel output register
// Forms the frame buffer byte offset and holds the pixel until transfer.
// ---------------------------------------------------------------------------
module brl_pixel_out #(
  parameter int FRAME_WIDTH = brl_pkg::FRAME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  brl_pkg::brl_emit_t emit,
  output logic               can_take,
  brl_pixel_if.source        pix_out
);

  localparam int WB     = $clog2(FRAME_WIDTH + 1);
  localparam int ROW_W  = WB + brl_pkg::Y_W;

  logic [ROW_W-1:0]              row_base;
  logic [brl_pkg::OFF_W-1:0]     lin;
  logic [brl_pkg::OFF_W-1:0]     offset;

  always_comb begin
    row_base = WB'(FRAME_WIDTH) * emit.pix.y;
    lin      = brl_pkg::OFF_W'(row_base) + brl_pkg::OFF_W'(emit.pix.x);
    // times three: add the doubled index
    offset   = lin + {lin[brl_pkg::OFF_W-2:0], 1'b0};
    can_take = !pix_out.valid || pix_out.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (can_take) begin
      pix_out.valid <= emit.valid;
    end
    if (can_take && emit.valid) begin
      pix_out.pixel_x      <= emit.pix.x;
      pix_out.pixel_y      <= emit.pix.y;
      pix_out.pixel_offset <= offset;
      pix_out.last_pixel   <= emit.pix.last;
    end
  end

endmodule

### rtl/bresenham_line_rasterizer_top.sv
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer_top: integer Bresenham line rasterizer
// Loads a line from two endpoints and steps it out one pixel per command.
// ---------------------------------------------------------------------------
// A load command (op = 0) takes two endpoints, picks the major axis (x when
// |dx| > |dy|, otherwise y), and sets the error term, its increments and the
// stepping directions; it gives no pixel and replaces any line in progress.
// Each step command (op = 1) emits the current pixel: its column, its row,
// the byte offset 3*(x + FRAME_WIDTH*y) of its RGB triple (low 20 bits) and
// a last mark on the final endpoint, which also ends the line. A step with
// no active line gives nothing; a zero-length line gives one pixel. No
// clipping is done. The block takes one command per clock: setup and one
// stepping iteration are combinational logic ahead of the line state
// register, so a line streams out without gaps while step commands arrive
// and the sink keeps ready high. The only stall comes from the output
// register: a new command is taken whenever that register is empty or its
// pixel transfers in the same cycle. A step transfer's pixel appears on the
// output in the cycle after the transfer.
// ---------------------------------------------------------------------------
module bresenham_line_rasterizer_top #(
  parameter int FRAME_WIDTH = brl_pkg::FRAME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  brl_line_if.sink    line_in,
  brl_pixel_if.source pixel_out
);

  brl_pkg::brl_line_t setup;
  brl_pkg::brl_emit_t emit;
  logic               can_take;
  logic               take;
  logic               line_active;

  // Accept a command whenever the output register can absorb a pixel
  assign line_in.ready = can_take;
  assign take          = line_in.valid && can_take;

  brl_setup u_setup (
    .x_start (line_in.x_start),
    .y_start (line_in.y_start),
    .x_end   (line_in.x_end),
    .y_end   (line_in.y_end),
    .line    (setup)
  );

  // Hold the line state, advance one pixel per step transfer
  brl_step u_step (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .op          (line_in.op),
    .setup       (setup),
    .emit        (emit),
    .line_active (line_active)
  );

  // Register the pixel with its frame buffer offset
  brl_pixel_out #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .can_take (can_take),
    .pix_out  (pixel_out)
  );

`ifndef SYNTH
  // A load transfer always leaves an active line behind
  a_load_activates: assert property (@(posedge clk) disable iff (rst)
    (line_in.valid && line_in.ready && (line_in.op == brl_pkg::OP_LOAD)) |=> line_active)
    else $error("line not active after load");

  // The final pixel ends the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && emit.pix.last) |=> !line_active)
    else $error("line still active after last pixel");

  // A step with no active line must not produce a pixel
  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (line_in.valid && line_in.ready && (line_in.op == brl_pkg::OP_STEP) && !line_active)
    |=> !$rose(pixel_out.valid))
    else $error("pixel produced with no active line");

  // Input stalls only behind a held, unaccepted pixel
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !line_in.ready |-> (pixel_out.valid && !pixel_out.ready))
    else $error("input stalled without output backpressure");
`endif

endmodule
